[rtl/dcr_pkg.sv]
package dcr_pkg;

    localparam int RELAX_ITERATIONS_DEF = 5;
    localparam int COORD_WIDTH_DEF      = 32;

    localparam int IO_W       = 32;
    localparam int REST_W     = 31;
    localparam int NORM_W     = 30;
    localparam int PROD_W     = 2 * NORM_W;
    localparam int NX_W       = NORM_W + REST_W;
    localparam int SQ_W       = 62;
    localparam int ROOT_W     = 31;
    localparam int ROOT_STEPS = 31;
    localparam int DEN_W      = ROOT_W + 1;
    localparam int NUM_W      = 63;
    localparam int QUO_W      = 31;
    localparam int QUO_STEPS  = 31;

    typedef struct packed {
        logic valid;
        logic coin;
        logic pin_a;
        logic pin_b;
    } dcr_ctl_t;

endpackage

[rtl/dcr_sqrt_cell.sv]
module dcr_sqrt_cell import dcr_pkg::*; #(
    parameter int K = 0
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [SQ_W-1:0] v_i,
    input  logic [SQ_W-1:0] res_i,
    output logic [SQ_W-1:0] v_o,
    output logic [SQ_W-1:0] res_o
);

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

    logic [SQ_W-1:0] trial;
    logic [SQ_W:0]   diff;
    logic [SQ_W-1:0] v_reg, v_next;
    logic [SQ_W-1:0] res_reg, res_next;

    assign trial = res_i + BIT;
    assign diff  = {1'b0, v_i} - {1'b0, trial};

    always_comb begin
        if (!diff[SQ_W]) begin
            v_next   = diff[SQ_W-1:0];
            res_next = (res_i >> 1) + BIT;
        end else begin
            v_next   = v_i;
            res_next = res_i >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg   <= v_next;
            res_reg <= res_next;
        end
    end

    assign v_o   = v_reg;
    assign res_o = res_reg;

endmodule

[rtl/dcr_div_cell.sv]
module dcr_div_cell import dcr_pkg::*; #(
    parameter int K = 0
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [DEN_W-1:0] den_i,
    input  logic [NUM_W-1:0] rx_i,
    input  logic [NUM_W-1:0] ry_i,
    input  logic [QUO_W-1:0] qx_i,
    input  logic [QUO_W-1:0] qy_i,
    output logic [DEN_W-1:0] den_o,
    output logic [NUM_W-1:0] rx_o,
    output logic [NUM_W-1:0] ry_o,
    output logic [QUO_W-1:0] qx_o,
    output logic [QUO_W-1:0] qy_o
);

    logic [NUM_W-1:0] dsh;
    logic [NUM_W:0]   diff_x, diff_y;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [QUO_W-1:0] qx_reg, qx_next, qy_reg, qy_next;

    assign dsh    = NUM_W'(den_i) << K;
    assign diff_x = {1'b0, rx_i} - {1'b0, dsh};
    assign diff_y = {1'b0, ry_i} - {1'b0, dsh};

    always_comb begin
        rx_next = diff_x[NUM_W] ? rx_i : diff_x[NUM_W-1:0];
        ry_next = diff_y[NUM_W] ? ry_i : diff_y[NUM_W-1:0];
        qx_next = qx_i | (QUO_W'(!diff_x[NUM_W]) << K);
        qy_next = qy_i | (QUO_W'(!diff_y[NUM_W]) << K);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= den_i;
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
        end
    end

    assign den_o = den_reg;
    assign rx_o  = rx_reg;
    assign ry_o  = ry_reg;
    assign qx_o  = qx_reg;
    assign qy_o  = qy_reg;

endmodule

[rtl/dcr_round.sv]
module dcr_round import dcr_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  dcr_ctl_t          ctl_i,
    input  logic [CW-1:0]     ax_i,
    input  logic [CW-1:0]     ay_i,
    input  logic [CW-1:0]     bx_i,
    input  logic [CW-1:0]     by_i,
    input  logic [REST_W-1:0] rest_i,
    output dcr_ctl_t          ctl_o,
    output logic [CW-1:0]     ax_o,
    output logic [CW-1:0]     ay_o,
    output logic [CW-1:0]     bx_o,
    output logic [CW-1:0]     by_o,
    output logic [REST_W-1:0] rest_o
);

    localparam int WD   = CW + 1;
    localparam int NSH  = (CW > NORM_W) ? CW - NORM_W : 0;
    localparam int NCTX = NSH + 66;
    localparam int MUL  = NSH + 1;
    localparam int WS   = ((CW > IO_W) ? CW : IO_W) + 2;
    localparam logic signed [WS-1:0] CW_HI = $signed((WS'(1) << (CW - 1)) - WS'(1));
    localparam logic signed [WS-1:0] CW_LO = -CW_HI - WS'(1);

    typedef struct packed {
        logic [CW-1:0]     ax;
        logic [CW-1:0]     ay;
        logic [CW-1:0]     bx;
        logic [CW-1:0]     by;
        logic [CW-1:0]     mx;
        logic [CW-1:0]     my;
        logic              sx;
        logic              sy;
        logic [REST_W-1:0] rest;
    } ctx_t;

    dcr_ctl_t ctl_reg [NCTX];
    dcr_ctl_t ctl_next;
    ctx_t     ctx_reg [NCTX];
    ctx_t     ctx_next;

    logic signed [WD-1:0] dx, dy, sum_x, sum_y;
    logic [CW-1:0]        mag_x_reg [NSH+1];
    logic [CW-1:0]        mag_y_reg [NSH+1];

    logic [NORM_W-1:0] ux_n, uy_n;
    logic [PROD_W-1:0] px_reg, py_reg;
    logic [NX_W-1:0]   nx_reg, ny_reg;
    logic [SQ_W-1:0]   sum_reg;

    logic [SQ_W-1:0]   sq_v [ROOT_STEPS+1];
    logic [SQ_W-1:0]   sq_r [ROOT_STEPS+1];
    logic [NX_W-1:0]   nxq_reg [ROOT_STEPS+1];
    logic [NX_W-1:0]   nyq_reg [ROOT_STEPS+1];
    logic [ROOT_W-1:0] len;

    logic [NUM_W-1:0] dv_rx [QUO_STEPS+1];
    logic [NUM_W-1:0] dv_ry [QUO_STEPS+1];
    logic [QUO_W-1:0] dv_qx [QUO_STEPS+1];
    logic [QUO_W-1:0] dv_qy [QUO_STEPS+1];
    logic [DEN_W-1:0] dv_den [QUO_STEPS+1];

    ctx_t                 cu;
    dcr_ctl_t             cl;
    logic signed [WS-1:0] mxs, mys, offx, offy;
    logic signed [WS-1:0] nax, nay, nbx, nby;

    dcr_ctl_t          upd_ctl_reg;
    logic [CW-1:0]     upd_ax_reg, upd_ay_reg, upd_bx_reg, upd_by_reg;
    logic [CW-1:0]     upd_ax_next, upd_ay_next, upd_bx_next, upd_by_next;
    logic [REST_W-1:0] upd_rest_reg;

    assign dx    = WD'($signed(ax_i)) - WD'($signed(bx_i));
    assign dy    = WD'($signed(ay_i)) - WD'($signed(by_i));
    assign sum_x = WD'($signed(ax_i)) + WD'($signed(bx_i));
    assign sum_y = WD'($signed(ay_i)) + WD'($signed(by_i));

    always_comb begin
        ctl_next       = ctl_i;
        ctl_next.coin  = ctl_i.coin | ((ax_i == bx_i) && (ay_i == by_i));
        ctx_next.ax    = ax_i;
        ctx_next.ay    = ay_i;
        ctx_next.bx    = bx_i;
        ctx_next.by    = by_i;
        ctx_next.mx    = CW'(sum_x >>> 1);
        ctx_next.my    = CW'(sum_y >>> 1);
        ctx_next.sx    = dx[WD-1];
        ctx_next.sy    = dy[WD-1];
        ctx_next.rest  = rest_i;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCTX; i++) begin
                ctl_reg[i] <= '0;
            end
            upd_ctl_reg <= '0;
        end else if (en) begin
            ctl_reg[0] <= ctl_next;
            for (int i = 1; i < NCTX; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            upd_ctl_reg <= ctl_reg[NCTX-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg[0] <= ctx_next;
            for (int i = 1; i < NCTX; i++) begin
                ctx_reg[i] <= ctx_reg[i-1];
            end
            mag_x_reg[0] <= CW'(dx[WD-1] ? -dx : dx);
            mag_y_reg[0] <= CW'(dy[WD-1] ? -dy : dy);
        end
    end

    for (genvar i = 1; i <= NSH; i++) begin : g_norm
        logic big;
        assign big = |((mag_x_reg[i-1] | mag_y_reg[i-1]) >> NORM_W);
        always_ff @(posedge aclk) begin
            if (en) begin
                mag_x_reg[i] <= big ? (mag_x_reg[i-1] >> 1) : mag_x_reg[i-1];
                mag_y_reg[i] <= big ? (mag_y_reg[i-1] >> 1) : mag_y_reg[i-1];
            end
        end
    end

    assign ux_n = NORM_W'(mag_x_reg[NSH]);
    assign uy_n = NORM_W'(mag_y_reg[NSH]);

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg     <= PROD_W'(ux_n) * PROD_W'(ux_n);
            py_reg     <= PROD_W'(uy_n) * PROD_W'(uy_n);
            nx_reg     <= NX_W'(ux_n) * NX_W'(ctx_reg[MUL-1].rest);
            ny_reg     <= NX_W'(uy_n) * NX_W'(ctx_reg[MUL-1].rest);
            sum_reg    <= SQ_W'(px_reg) + SQ_W'(py_reg);
            nxq_reg[0] <= nx_reg;
            nyq_reg[0] <= ny_reg;
            for (int i = 1; i <= ROOT_STEPS; i++) begin
                nxq_reg[i] <= nxq_reg[i-1];
                nyq_reg[i] <= nyq_reg[i-1];
            end
        end
    end

    assign sq_v[0] = sum_reg;
    assign sq_r[0] = '0;

    for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
        dcr_sqrt_cell #(.K(ROOT_STEPS - 1 - i)) u_cell (
            .aclk  (aclk),
            .en    (en),
            .v_i   (sq_v[i]),
            .res_i (sq_r[i]),
            .v_o   (sq_v[i+1]),
            .res_o (sq_r[i+1])
        );
    end

    assign len = sq_r[ROOT_STEPS][ROOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_rx[0]  <= NUM_W'(nxq_reg[ROOT_STEPS]) + NUM_W'(len);
            dv_ry[0]  <= NUM_W'(nyq_reg[ROOT_STEPS]) + NUM_W'(len);
            dv_den[0] <= {len, 1'b0};
        end
    end

    assign dv_qx[0] = '0;
    assign dv_qy[0] = '0;

    for (genvar i = 0; i < QUO_STEPS; i++) begin : g_quo
        dcr_div_cell #(.K(QUO_STEPS - 1 - i)) u_cell (
            .aclk  (aclk),
            .en    (en),
            .den_i (dv_den[i]),
            .rx_i  (dv_rx[i]),
            .ry_i  (dv_ry[i]),
            .qx_i  (dv_qx[i]),
            .qy_i  (dv_qy[i]),
            .den_o (dv_den[i+1]),
            .rx_o  (dv_rx[i+1]),
            .ry_o  (dv_ry[i+1]),
            .qx_o  (dv_qx[i+1]),
            .qy_o  (dv_qy[i+1])
        );
    end

    assign cu   = ctx_reg[NCTX-1];
    assign cl   = ctl_reg[NCTX-1];
    assign mxs  = WS'($signed(cu.mx));
    assign mys  = WS'($signed(cu.my));
    assign offx = cu.sx ? -$signed(WS'(dv_qx[QUO_STEPS])) : $signed(WS'(dv_qx[QUO_STEPS]));
    assign offy = cu.sy ? -$signed(WS'(dv_qy[QUO_STEPS])) : $signed(WS'(dv_qy[QUO_STEPS]));
    assign nax  = mxs + offx;
    assign nay  = mys + offy;
    assign nbx  = mxs - offx;
    assign nby  = mys - offy;

    always_comb begin
        upd_ax_next = cu.ax;
        upd_ay_next = cu.ay;
        upd_bx_next = cu.bx;
        upd_by_next = cu.by;
        if (!cl.coin && !cl.pin_a) begin
            upd_ax_next = (nax > CW_HI) ? CW'(CW_HI) : (nax < CW_LO) ? CW'(CW_LO) : CW'(nax);
            upd_ay_next = (nay > CW_HI) ? CW'(CW_HI) : (nay < CW_LO) ? CW'(CW_LO) : CW'(nay);
        end
        if (!cl.coin && !cl.pin_b) begin
            upd_bx_next = (nbx > CW_HI) ? CW'(CW_HI) : (nbx < CW_LO) ? CW'(CW_LO) : CW'(nbx);
            upd_by_next = (nby > CW_HI) ? CW'(CW_HI) : (nby < CW_LO) ? CW'(CW_LO) : CW'(nby);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            upd_ax_reg   <= upd_ax_next;
            upd_ay_reg   <= upd_ay_next;
            upd_bx_reg   <= upd_bx_next;
            upd_by_reg   <= upd_by_next;
            upd_rest_reg <= cu.rest;
        end
    end

    assign ctl_o  = upd_ctl_reg;
    assign ax_o   = upd_ax_reg;
    assign ay_o   = upd_ay_reg;
    assign bx_o   = upd_bx_reg;
    assign by_o   = upd_by_reg;
    assign rest_o = upd_rest_reg;

endmodule

[rtl/distance_constraint_relax.sv]
// channel  direction  handshake          payload
// s_       in         s_valid/s_ready    two points, pin flags, rest length
// m_       out        m_valid/m_ready    two relaxed points, coincident flag
//
// One request per cycle while the pipeline is not held. Every round holds a 31-cell
// square root chain and a 31-cell divider chain. Reset (aresetn low) empties the pipeline.
// The whole pipeline holds while a result waits in the output register and the
// last stage is full; a bubble in the last stage keeps it moving.
module distance_constraint_relax import dcr_pkg::*; #(
    parameter int RELAX_ITERATIONS = RELAX_ITERATIONS_DEF,
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [IO_W-1:0]   s_first_x,
    input  logic [IO_W-1:0]   s_first_y,
    input  logic [IO_W-1:0]   s_second_x,
    input  logic [IO_W-1:0]   s_second_y,
    input  logic              s_first_pinned,
    input  logic              s_second_pinned,
    input  logic [REST_W-1:0] s_rest_length,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [IO_W-1:0]   m_new_first_x,
    output logic [IO_W-1:0]   m_new_first_y,
    output logic [IO_W-1:0]   m_new_second_x,
    output logic [IO_W-1:0]   m_new_second_y,
    output logic              m_coincident
);

    localparam int CW = COORD_WIDTH;
    localparam int WX = ((CW > IO_W) ? CW : IO_W) + 1;
    localparam logic signed [WX-1:0] CW_HI = $signed((WX'(1) << (CW - 1)) - WX'(1));
    localparam logic signed [WX-1:0] CW_LO = -CW_HI - WX'(1);
    localparam logic signed [WX-1:0] IO_HI = $signed((WX'(1) << (IO_W - 1)) - WX'(1));
    localparam logic signed [WX-1:0] IO_LO = -IO_HI - WX'(1);

    function automatic logic [CW-1:0] to_cw(logic [IO_W-1:0] x);
        logic signed [WX-1:0] e;
        e = WX'($signed(x));
        if (e > CW_HI) return CW'(CW_HI);
        if (e < CW_LO) return CW'(CW_LO);
        return CW'(e);
    endfunction

    function automatic logic [IO_W-1:0] to_io(logic [CW-1:0] p);
        logic signed [WX-1:0] e;
        e = WX'($signed(p));
        if (e > IO_HI) return IO_W'(IO_HI);
        if (e < IO_LO) return IO_W'(IO_LO);
        return IO_W'(e);
    endfunction

    dcr_ctl_t          r_ctl  [RELAX_ITERATIONS+1];
    logic [CW-1:0]     r_ax   [RELAX_ITERATIONS+1];
    logic [CW-1:0]     r_ay   [RELAX_ITERATIONS+1];
    logic [CW-1:0]     r_bx   [RELAX_ITERATIONS+1];
    logic [CW-1:0]     r_by   [RELAX_ITERATIONS+1];
    logic [REST_W-1:0] r_rest [RELAX_ITERATIONS+1];

    logic            en, last;
    logic            m_valid_reg, m_valid_next;
    logic [IO_W-1:0] fx_reg, fy_reg, sx_reg, sy_reg;
    logic            coin_reg;

    assign last    = r_ctl[RELAX_ITERATIONS].valid;
    assign en      = !m_valid_reg || m_ready || !last;
    assign s_ready = en;

    assign r_ctl[0].valid = s_valid;
    assign r_ctl[0].coin  = 1'b0;
    assign r_ctl[0].pin_a = s_first_pinned;
    assign r_ctl[0].pin_b = s_second_pinned;
    assign r_ax[0]        = to_cw(s_first_x);
    assign r_ay[0]        = to_cw(s_first_y);
    assign r_bx[0]        = to_cw(s_second_x);
    assign r_by[0]        = to_cw(s_second_y);
    assign r_rest[0]      = s_rest_length;

    for (genvar r = 0; r < RELAX_ITERATIONS; r++) begin : g_round
        dcr_round #(.CW(CW)) u_round (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_i   (r_ctl[r]),
            .ax_i    (r_ax[r]),
            .ay_i    (r_ay[r]),
            .bx_i    (r_bx[r]),
            .by_i    (r_by[r]),
            .rest_i  (r_rest[r]),
            .ctl_o   (r_ctl[r+1]),
            .ax_o    (r_ax[r+1]),
            .ay_o    (r_ay[r+1]),
            .bx_o    (r_bx[r+1]),
            .by_o    (r_by[r+1]),
            .rest_o  (r_rest[r+1])
        );
    end

    always_comb begin
        if (en && last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (en && last) begin
            fx_reg   <= to_io(r_ax[RELAX_ITERATIONS]);
            fy_reg   <= to_io(r_ay[RELAX_ITERATIONS]);
            sx_reg   <= to_io(r_bx[RELAX_ITERATIONS]);
            sy_reg   <= to_io(r_by[RELAX_ITERATIONS]);
            coin_reg <= r_ctl[RELAX_ITERATIONS].coin;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_new_first_x  = fx_reg;
    assign m_new_first_y  = fy_reg;
    assign m_new_second_x = sx_reg;
    assign m_new_second_y = sy_reg;
    assign m_coincident   = coin_reg;

endmodule

[rtl/dcr_checker.sv]
module dcr_checker import dcr_pkg::*; (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input logic [IO_W-1:0] m_new_first_x,
    input logic [IO_W-1:0] m_new_second_x,
    input logic            m_coincident
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) !m_valid |-> s_ready)
        else $error("request refused with empty output");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("stalled result dropped");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_new_first_x) && $stable(m_new_second_x)
            && $stable(m_coincident))
        else $error("stalled result changed");

endmodule

bind distance_constraint_relax dcr_checker u_dcr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_new_first_x  (m_new_first_x),
    .m_new_second_x (m_new_second_x),
    .m_coincident   (m_coincident)
);

[dv/tb.sv]
module tb;
    import dcr_pkg::*;

    typedef struct packed {
        logic [IO_W-1:0]   ax, ay, bx, by;
        logic              pa, pb;
        logic [REST_W-1:0] rest;
    } link_t;

    typedef struct packed {
        logic [IO_W-1:0] ax, ay, bx, by;
        logic            coin;
    } relaxed_t;

    localparam int ROUNDS      = RELAX_ITERATIONS_DEF;
    localparam int LATENCY     = 346;
    localparam int LONG_HOLD   = 1500;
    localparam int RANDOM_REQS = 1850;

    class link_scoreboard;
        relaxed_t pending[$];
        int       errors = 0;

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint floor_half(longint s);
            if (s >= 0) return s / 2;
            return -((-s + 1) / 2);
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned res, bit_w;
            res = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > v) bit_w >>= 2;
            while (bit_w != 0) begin
                if (v >= res + bit_w) begin
                    v -= res + bit_w;
                    res = (res >> 1) + bit_w;
                end else begin
                    res >>= 1;
                end
                bit_w >>= 2;
            end
            return res;
        endfunction

        function relaxed_t relax(link_t r);
            longint ax, ay, bx, by, dx, dy, mx, my, ox, oy;
            longint unsigned ux, uy, len, rest;
            relaxed_t e;
            ax = longint'($signed(r.ax));
            ay = longint'($signed(r.ay));
            bx = longint'($signed(r.bx));
            by = longint'($signed(r.by));
            rest = longint'(r.rest);
            e.coin = 1'b0;
            for (int it = 0; it < ROUNDS; it++) begin
                dx = ax - bx;
                dy = ay - by;
                if (dx == 0 && dy == 0) begin
                    e.coin = 1'b1;
                    break;
                end
                mx = floor_half(ax + bx);
                my = floor_half(ay + by);
                ux = dx < 0 ? -dx : dx;
                uy = dy < 0 ? -dy : dy;
                while (ux >= (64'd1 << 30) || uy >= (64'd1 << 30)) begin
                    ux >>= 1;
                    uy >>= 1;
                end
                len = root(ux * ux + uy * uy);
                ox = (ux * rest + len) / (2 * len);
                oy = (uy * rest + len) / (2 * len);
                if (dx < 0) ox = -ox;
                if (dy < 0) oy = -oy;
                if (!r.pa) begin
                    ax = sat32(mx + ox);
                    ay = sat32(my + oy);
                end
                if (!r.pb) begin
                    bx = sat32(mx - ox);
                    by = sat32(my - oy);
                end
            end
            e.ax = ax[31:0];
            e.ay = ay[31:0];
            e.bx = bx[31:0];
            e.by = by[31:0];
            return e;
        endfunction

        function void note(link_t r);
            pending.push_back(relax(r));
        endfunction

        function void check(relaxed_t got);
            relaxed_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h %h %h %h %b",
                    got.ax, got.ay, got.bx, got.by, got.coin);
                return;
            end
            e = pending.pop_front();
            if (e != got) begin
                errors++;
                if (errors <= 10) $display("mismatch exp %h %h %h %h %b got %h %h %h %h %b",
                    e.ax, e.ay, e.bx, e.by, e.coin, got.ax, got.ay, got.bx, got.by, got.coin);
            end
        endfunction
    endclass

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_valid = 0;
    logic              s_ready;
    logic [IO_W-1:0]   s_first_x = '0, s_first_y = '0, s_second_x = '0, s_second_y = '0;
    logic              s_first_pinned = 0, s_second_pinned = 0;
    logic [REST_W-1:0] s_rest_length = '0;
    logic              m_valid;
    logic              m_ready = 0;
    logic [IO_W-1:0]   m_new_first_x, m_new_first_y, m_new_second_x, m_new_second_y;
    logic              m_coincident;

    link_scoreboard sb = new();
    bit calm = 0;
    bit long_hold = 0;

    distance_constraint_relax DUT (.*);

    initial forever #4 aclk = ~aclk;

    initial begin
        #(8 * 400000);
        $display("tb: errors");
        $finish;
    end

    always @(posedge aclk) begin
        relaxed_t got;
        if (aresetn && m_valid && m_ready) begin
            got.ax = m_new_first_x;
            got.ay = m_new_first_y;
            got.bx = m_new_second_x;
            got.by = m_new_second_y;
            got.coin = m_coincident;
            sb.check(got);
        end
    end

    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold = 0;
            end else if (calm) begin
                m_ready <= 1;
                @(posedge aclk);
            end else begin
                n = $urandom_range(1, 9);
                m_ready <= $urandom_range(0, 2) != 0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic send(link_t r);
        s_valid <= 1;
        s_first_x <= r.ax;
        s_first_y <= r.ay;
        s_second_x <= r.bx;
        s_second_y <= r.by;
        s_first_pinned <= r.pa;
        s_second_pinned <= r.pb;
        s_rest_length <= r.rest;
        do @(posedge aclk); while (!s_ready);
        sb.note(r);
    endtask

    task automatic gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    function automatic link_t mk(logic [31:0] ax, ay, bx, by, logic pa, pb,
                                 logic [30:0] rest);
        link_t r;
        r.ax = ax; r.ay = ay; r.bx = bx; r.by = by;
        r.pa = pa; r.pb = pb; r.rest = rest;
        return r;
    endfunction

    function automatic link_t random_link();
        link_t r;
        int kind;
        kind = $urandom_range(0, 9);
        r = mk(32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 31'($urandom));
        if (kind >= 4 && kind <= 7) begin
            r.ax = $signed(r.ax) >>> $urandom_range(0, 16);
            r.ay = $signed(r.ay) >>> $urandom_range(0, 16);
            r.bx = r.ax + ($signed($urandom) >>> $urandom_range(8, 30));
            r.by = r.ay + ($signed($urandom) >>> $urandom_range(8, 30));
            r.rest = r.rest >> $urandom_range(0, 24);
        end else if (kind >= 8) begin
            r.bx = r.ax;
            r.by = r.ay;
        end
        return r;
    endfunction

    initial begin
        link_t d[$];
        d.push_back(mk(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 0, 0, 31'h1_0000));
        d.push_back(mk(32'h0, 32'h0, 32'h0, 32'h0, 1, 1, 31'h0));
        d.push_back(mk(32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 0, 0, 31'h000A_0000));
        d.push_back(mk(32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 1, 0, 31'h000A_0000));
        d.push_back(mk(32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 0, 1, 31'h000A_0000));
        d.push_back(mk(32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 1, 1, 31'h000A_0000));
        d.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                       0, 0, 31'h7FFF_FFFF));
        d.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       0, 0, 31'h0));
        d.push_back(mk(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 1, 0, 31'h7FFF_FFFF));
        d.push_back(mk(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFE, 32'h0, 0, 0, 31'h7FFF_FFFF));
        d.push_back(mk(32'h8000_0000, 32'h1, 32'h8000_0000, 32'h0, 0, 0, 31'h7FFF_FFFF));
        d.push_back(mk(32'h1, 32'h1, 32'h0, 32'h0, 0, 0, 31'h0));
        d.push_back(mk(32'h1, 32'h0, 32'h0, 32'h0, 0, 0, 31'h1));
        d.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h1, 0, 0, 31'h3));
        d.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       0, 1, 31'h7FFF_FFFF));
        d.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       1, 0, 31'h1));
        d.push_back(mk(32'h0010_0000, 32'hFFF0_0000, 32'hFFF0_0000, 32'h0010_0000,
                       0, 0, 31'h0002_0000));
        d.push_back(mk(32'h0, 32'h0, 32'h0, 32'h0001_0000, 0, 0, 31'h1_0000));

        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (d[i]) begin
            send(d[i]);
            gap();
        end

        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (i == 300) long_hold = 1;
            if (i == 1000) begin
                s_valid <= 0;
                while (sb.pending.size() != 0) @(posedge aclk);
            end
            if (i == RANDOM_REQS - 300) calm = 1;
            send(random_link());
            gap();
        end
        s_valid <= 0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/dcr_pkg.sv
rtl/dcr_sqrt_cell.sv
rtl/dcr_div_cell.sv
rtl/dcr_round.sv
rtl/distance_constraint_relax.sv
rtl/dcr_checker.sv
dv/tb.sv
